[hw/rtl/ddcrfc_pkg.sv]
// Shared types and constants for the DDC/CI reply frame checker.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package ddcrfc_pkg;

  localparam int MaxPayload = 32;
  localparam int PtrW       = $clog2(MaxPayload);
  localparam int LenW       = 6;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 7;

  localparam logic [7:0] BusyA    = 8'h51;
  localparam logic [7:0] BusyB    = 8'hFF;
  localparam logic [7:0] XorSeed  = 8'h50;
  localparam logic [7:0] LenFlag  = 8'h80;

  localparam logic [CfgIdxW-1:0] CfgDeviceAddr = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxLen     = 1'b1;

  localparam logic [2:0] StOk   = 3'd0;
  localparam logic [2:0] StBusy = 3'd1;
  localparam logic [2:0] StAddr = 3'd2;
  localparam logic [2:0] StFlag = 3'd3;
  localparam logic [2:0] StLong = 3'd4;
  localparam logic [2:0] StSum  = 3'd5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [7:0]      payload_byte;
    logic            has_data;
    logic [2:0]      status;
    logic [LenW-1:0] payload_length;
    logic            last;
  } out_t;

  typedef enum logic [1:0] {
    EvNone,
    EvResult,
    EvRun
  } byte_ev_e;

  typedef enum logic {
    StateRecv,
    StateDrain
  } ctrl_state_e;

  typedef struct packed {
    logic take_byte;
    logic load_result;
    logic load_drain;
  } cmd_t;

  typedef struct packed {
    byte_ev_e ev;
    logic     drain_last;
  } sts_t;

endpackage

[hw/rtl/ddcrfc_dp.sv]
// Datapath: config registers, frame tracking, payload buffer, output register.
// Depends on ddcrfc_pkg; driven by ddcrfc_ctrl through cmd/status structs.
`timescale 1ns / 1ps

module ddcrfc_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ddcrfc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ddcrfc_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  ddcrfc_pkg::in_t                    in_data_i,
  input  ddcrfc_pkg::cmd_t                   cmd_i,
  output ddcrfc_pkg::sts_t                   sts_o,
  output ddcrfc_pkg::out_t                   out_data_o
);

  localparam int LenW = ddcrfc_pkg::LenW;
  localparam int PtrW = ddcrfc_pkg::PtrW;

  logic [6:0]      device_addr_q;
  logic [LenW-1:0] max_len_q;

  logic [LenW-1:0] byte_index_q, byte_index_d;
  logic [7:0]      running_xor_q, running_xor_d;
  logic [LenW-1:0] frame_length_q, frame_length_d;
  logic            frame_active_q, frame_active_d;
  logic [PtrW-1:0] rd_ptr_q;

  logic [7:0] store_q [ddcrfc_pkg::MaxPayload];
  logic       store_we;
  logic [PtrW-1:0] store_addr;

  ddcrfc_pkg::out_t out_q, res;
  ddcrfc_pkg::byte_ev_e ev;

  logic [7:0]      b;
  logic [6:0]      len;
  logic [LenW-1:0] eff_idx, eff_len;
  logic [LenW-1:0] slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_addr_q <= 7'd55;
      max_len_q     <= LenW'(8);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ddcrfc_pkg::CfgDeviceAddr: device_addr_q <= cfg_wdata_i[6:0];
        ddcrfc_pkg::CfgMaxLen:     max_len_q     <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Per-byte frame check
  always_comb begin
    b              = in_data_i.rx_byte;
    len            = b[6:0];
    eff_idx        = in_data_i.frame_start ? '0 : byte_index_q;
    eff_len        = in_data_i.frame_start ? '0 : frame_length_q;
    running_xor_d  = (in_data_i.frame_start ? ddcrfc_pkg::XorSeed : running_xor_q) ^ b;
    byte_index_d   = eff_idx;
    frame_length_d = eff_len;
    frame_active_d = in_data_i.frame_start | frame_active_q;
    slot           = eff_idx - LenW'(2);
    store_addr     = slot[PtrW-1:0];
    store_we       = 1'b0;
    ev             = ddcrfc_pkg::EvNone;
    res            = '0;
    res.last       = 1'b1;
    res.status     = ddcrfc_pkg::StOk;

    if (!frame_active_d) begin
      running_xor_d = running_xor_q;
    end else if (eff_idx == '0) begin
      if (b == ddcrfc_pkg::BusyA || b == ddcrfc_pkg::BusyB) begin
        ev = ddcrfc_pkg::EvResult;
        res.status = ddcrfc_pkg::StBusy;
        frame_active_d = 1'b0;
      end else if (b != {device_addr_q, 1'b0}) begin
        ev = ddcrfc_pkg::EvResult;
        res.status = ddcrfc_pkg::StAddr;
        frame_active_d = 1'b0;
      end else begin
        byte_index_d = LenW'(1);
      end
    end else if (eff_idx == LenW'(1)) begin
      if ((b & ddcrfc_pkg::LenFlag) == 8'h00) begin
        ev = ddcrfc_pkg::EvResult;
        res.status = ddcrfc_pkg::StFlag;
        frame_active_d = 1'b0;
      end else if (len > {1'b0, max_len_q} || len > 7'(ddcrfc_pkg::MaxPayload)) begin
        ev = ddcrfc_pkg::EvResult;
        res.status = ddcrfc_pkg::StLong;
        frame_active_d = 1'b0;
      end else begin
        frame_length_d = len[LenW-1:0];
        byte_index_d   = LenW'(2);
      end
    end else if ({1'b0, eff_idx} < {1'b0, eff_len} + (LenW+1)'(2)) begin
      store_we     = 1'b1;
      byte_index_d = eff_idx + LenW'(1);
    end else begin
      // checksum byte closes the frame
      frame_active_d = 1'b0;
      if (running_xor_d != 8'h00) begin
        ev = ddcrfc_pkg::EvResult;
        res.status = ddcrfc_pkg::StSum;
        res.payload_length = eff_len;
      end else if (eff_len == '0) begin
        ev = ddcrfc_pkg::EvResult;
      end else begin
        ev = ddcrfc_pkg::EvRun;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q   <= '0;
      running_xor_q  <= ddcrfc_pkg::XorSeed;
      frame_length_q <= '0;
      frame_active_q <= 1'b0;
      rd_ptr_q       <= '0;
    end else begin
      if (cmd_i.take_byte) begin
        byte_index_q   <= byte_index_d;
        running_xor_q  <= running_xor_d;
        frame_length_q <= frame_length_d;
        frame_active_q <= frame_active_d;
        rd_ptr_q       <= '0;
      end else if (cmd_i.load_drain) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && store_we) begin
      store_q[store_addr] <= b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      out_q <= res;
    end else if (cmd_i.load_drain) begin
      out_q.payload_byte   <= store_q[rd_ptr_q];
      out_q.has_data       <= 1'b1;
      out_q.status         <= ddcrfc_pkg::StOk;
      out_q.payload_length <= frame_length_q;
      out_q.last           <= sts_o.drain_last;
    end
  end

  assign sts_o.ev         = ev;
  assign sts_o.drain_last = (LenW'(rd_ptr_q) + LenW'(1)) == frame_length_q;
  assign out_data_o       = out_q;

endmodule

[hw/rtl/ddcrfc_ctrl.sv]
// Controller: byte intake versus payload release, output valid flag.
// Depends on ddcrfc_pkg; commands ddcrfc_dp.
`timescale 1ns / 1ps

module ddcrfc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ddcrfc_pkg::sts_t  sts_i,
  output ddcrfc_pkg::cmd_t  cmd_o
);

  ddcrfc_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ddcrfc_pkg::StateRecv: begin
        if (in_valid_i && out_free && sts_i.ev == ddcrfc_pkg::EvRun) begin
          state_d = ddcrfc_pkg::StateDrain;
        end
      end
      ddcrfc_pkg::StateDrain: begin
        if (out_free && sts_i.drain_last) begin
          state_d = ddcrfc_pkg::StateRecv;
        end
      end
      default: state_d = ddcrfc_pkg::StateRecv;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ddcrfc_pkg::StateRecv: begin
        in_ready_o      = out_free;
        cmd_o.take_byte = in_valid_i && out_free;
        if (cmd_o.take_byte && sts_i.ev == ddcrfc_pkg::EvResult) begin
          cmd_o.load_result = 1'b1;
          out_valid_d       = 1'b1;
        end
      end
      ddcrfc_pkg::StateDrain: begin
        if (out_free) begin
          cmd_o.load_drain = 1'b1;
          out_valid_d      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ddcrfc_pkg::StateRecv;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/ddc_ci_reply_frame_checker.sv]
// Timing: a byte is checked in the cycle it is accepted; a status result is valid the cycle
// after acceptance; the first payload result of a good frame follows once the drain state has
// loaded the first buffered byte. Throughput: one byte per cycle while the output is free; a
// good frame holds off input while the payload buffer drains, longer when the output stalls.
// Reset (async, active low): no frame active, checksum seed 0x50, device_addr 55,
// max_len 8, output empty. Payload buffer is not cleared.
`timescale 1ns / 1ps

module ddc_ci_reply_frame_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ddcrfc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ddcrfc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ddcrfc_pkg::in_t                   in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output ddcrfc_pkg::out_t                  out_data_o
);

  ddcrfc_pkg::cmd_t cmd;
  ddcrfc_pkg::sts_t sts;

  ddcrfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ddcrfc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

[hw/rtl/ddcrfc_sva.sv]
// Port-level checker for the reply frame checker, bound to the top level.
// Depends on ddcrfc_pkg.
`timescale 1ns / 1ps

module ddcrfc_sva (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input ddcrfc_pkg::in_t                   in_data_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input ddcrfc_pkg::out_t                  out_data_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input transaction dropped or changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction dropped or changed while stalled");

  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.has_data |-> out_data_o.status == ddcrfc_pkg::StOk)
    else $error("payload byte released with error status");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_data |->
      out_data_o.last && out_data_o.payload_byte == 8'h00)
    else $error("status transaction not final or carries data");

  a_early_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ddcrfc_pkg::StBusy ||
                    out_data_o.status == ddcrfc_pkg::StAddr ||
                    out_data_o.status == ddcrfc_pkg::StFlag ||
                    out_data_o.status == ddcrfc_pkg::StLong)
      |-> out_data_o.payload_length == '0)
    else $error("early error reports a nonzero length");

endmodule

bind ddc_ci_reply_frame_checker ddcrfc_sva u_sva (.*);
